// ===== rtl/rotary_set_countdown_timer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rotary set countdown timer
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ROTARY_SET_COUNTDOWN_TIMER_MACROS_SVH
`define ROTARY_SET_COUNTDOWN_TIMER_MACROS_SVH

// Same-cycle implication.
`define RSCT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RSCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rsct_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotary set countdown timer package
// Register map, reset values and fixed constants of the timer.
// ----------------------------------------------------------------------------
package rsct_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned REG_IDX_W = 3;

  // Register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_TICKS_PER_SECOND   = 3'd0,
    REG_START_LOCKOUT      = 3'd1,
    REG_ENCODER_LOCKOUT    = 3'd2,
    REG_BLINK_FAR          = 3'd3,
    REG_BLINK_NEAR         = 3'd4,
    REG_BLINK_LAST_MINUTE  = 3'd5,
    REG_BLINK_FINAL        = 3'd6
  } cfg_reg_e;

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_TICKS_PER_SECOND  = 16'd1000;
  localparam logic [CFG_W-1:0] RST_START_LOCKOUT     = 16'd200;
  localparam logic [CFG_W-1:0] RST_ENCODER_LOCKOUT   = 16'd50;
  localparam logic [CFG_W-1:0] RST_BLINK_FAR         = 16'd4000;
  localparam logic [CFG_W-1:0] RST_BLINK_NEAR        = 16'd2000;
  localparam logic [CFG_W-1:0] RST_BLINK_LAST_MINUTE = 16'd1000;
  localparam logic [CFG_W-1:0] RST_BLINK_FINAL       = 16'd200;

  // Parameter defaults.
  localparam int unsigned MAX_MINUTES_DEF = 99;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Field widths.
  localparam int unsigned MIN_W  = 7;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned DISP_W = 14;

  // Time constants.
  localparam logic [SEC_W-1:0]  SEC_LAST      = 6'd59;
  localparam logic [SEC_W-1:0]  SEC_STEP      = 6'd5;
  localparam logic [SEC_W-1:0]  SEC_WRAP_FROM = 6'd55;   // +5 reaches 60 from here
  localparam logic [SEC_W-1:0]  SEC_BORROW    = 6'd55;   // value after a down borrow
  localparam logic [SEC_W-1:0]  SEC_FINAL     = 6'd30;
  localparam logic [MIN_W-1:0]  MIN_WARN      = 7'd4;
  localparam logic [MIN_W-1:0]  MIN_FAR       = 7'd2;
  localparam logic [MIN_W-1:0]  MIN_NEAR      = 7'd1;
  localparam logic [DISP_W-1:0] DISP_SCALE    = 14'd100;

endpackage

// ===== rtl/rotary_set_countdown_timer.sv =====
// ----------------------------------------------------------------------------
// Rotary set countdown timer
// Tick-driven countdown timer set by two quadrature encoders.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word is one tick sample (nominally one millisecond) of the
//   reset button, the start/stop button and the clock and data pins of the
//   minute and second encoders. For every accepted input word the block
//   returns exactly one output word: the time left, the running flag, a
//   one-tick warning pulse and the time as a four-digit decimal value.
//   Both channels use a valid/ready handshake. The configuration registers
//   sit on an APB-style port at byte address 4*i, read back with pready
//   always high; write them only while no word is in flight.
//   A word is captured in the input register; the whole tick update then runs
//   through one pass of logic into the timer state and the output register.
//   Throughput is one word per cycle, set by that single pass, as long as the
//   receiver takes each output word. While the output word waits, the input
//   register takes one more word and then holds it.
//   When the receiver stalls, the output word holds, the input register
//   fills and in_ready_o drops until the output is taken.
//   Reset clears the time to 0:00, stops the timer, loads the register
//   defaults and empties both pipeline stages; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "rotary_set_countdown_timer_macros.svh"

module rotary_set_countdown_timer #(
  parameter int unsigned MAX_MINUTES = rsct_pkg::MAX_MINUTES_DEF,
  parameter int unsigned COUNT_WIDTH = rsct_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               reset_button_n_i,
  input  logic                               start_button_n_i,
  input  logic                               minute_enc_clk_i,
  input  logic                               minute_enc_dt_i,
  input  logic                               second_enc_clk_i,
  input  logic                               second_enc_dt_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rsct_pkg::MIN_W-1:0]         minutes_left_o,
  output logic [rsct_pkg::SEC_W-1:0]         seconds_left_o,
  output logic                               active_led_o,
  output logic                               warn_pulse_o,
  output logic [rsct_pkg::DISP_W-1:0]        display_value_o,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rsct_pkg::PADDR_W-1:0]       paddr,
  input  logic [rsct_pkg::PDATA_W-1:0]       pwdata,
  output logic [rsct_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  // Counters and registers are compared at the wider of the two widths.
  localparam int unsigned CmpW =
    (COUNT_WIDTH > rsct_pkg::CFG_W) ? COUNT_WIDTH : rsct_pkg::CFG_W;
  localparam logic [rsct_pkg::MIN_W-1:0] MaxMin = rsct_pkg::MIN_W'(MAX_MINUTES);

  typedef logic [COUNT_WIDTH-1:0]    cnt_t;
  typedef logic [rsct_pkg::CFG_W-1:0] cfg_t;
  typedef logic [CmpW-1:0]           cmp_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t cfg_tps_q, cfg_start_q, cfg_enc_q;
  cfg_t cfg_far_q, cfg_near_q, cfg_last_q, cfg_final_q;

  rsct_pkg::cfg_reg_e reg_idx;
  logic               cfg_wr;

  assign reg_idx = rsct_pkg::cfg_reg_e'(paddr[rsct_pkg::PADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_tps_q   <= rsct_pkg::RST_TICKS_PER_SECOND;
      cfg_start_q <= rsct_pkg::RST_START_LOCKOUT;
      cfg_enc_q   <= rsct_pkg::RST_ENCODER_LOCKOUT;
      cfg_far_q   <= rsct_pkg::RST_BLINK_FAR;
      cfg_near_q  <= rsct_pkg::RST_BLINK_NEAR;
      cfg_last_q  <= rsct_pkg::RST_BLINK_LAST_MINUTE;
      cfg_final_q <= rsct_pkg::RST_BLINK_FINAL;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rsct_pkg::REG_TICKS_PER_SECOND:  cfg_tps_q   <= pwdata[rsct_pkg::CFG_W-1:0];
        rsct_pkg::REG_START_LOCKOUT:     cfg_start_q <= pwdata[rsct_pkg::CFG_W-1:0];
        rsct_pkg::REG_ENCODER_LOCKOUT:   cfg_enc_q   <= pwdata[rsct_pkg::CFG_W-1:0];
        rsct_pkg::REG_BLINK_FAR:         cfg_far_q   <= pwdata[rsct_pkg::CFG_W-1:0];
        rsct_pkg::REG_BLINK_NEAR:        cfg_near_q  <= pwdata[rsct_pkg::CFG_W-1:0];
        rsct_pkg::REG_BLINK_LAST_MINUTE: cfg_last_q  <= pwdata[rsct_pkg::CFG_W-1:0];
        rsct_pkg::REG_BLINK_FINAL:       cfg_final_q <= pwdata[rsct_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rsct_pkg::REG_TICKS_PER_SECOND:  prdata = rsct_pkg::PDATA_W'(cfg_tps_q);
      rsct_pkg::REG_START_LOCKOUT:     prdata = rsct_pkg::PDATA_W'(cfg_start_q);
      rsct_pkg::REG_ENCODER_LOCKOUT:   prdata = rsct_pkg::PDATA_W'(cfg_enc_q);
      rsct_pkg::REG_BLINK_FAR:         prdata = rsct_pkg::PDATA_W'(cfg_far_q);
      rsct_pkg::REG_BLINK_NEAR:        prdata = rsct_pkg::PDATA_W'(cfg_near_q);
      rsct_pkg::REG_BLINK_LAST_MINUTE: prdata = rsct_pkg::PDATA_W'(cfg_last_q);
      rsct_pkg::REG_BLINK_FINAL:       prdata = rsct_pkg::PDATA_W'(cfg_final_q);
      default:                         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: input register, then the update into the output stage.
  // --------------------------------------------------------------------------
  logic s1_valid_q, out_valid_q, adv;
  logic s1_rst_n_q, s1_start_n_q, s1_mclk_q, s1_mdt_q, s1_sclk_q, s1_sdt_q;

  // The update fires when a word waits in the input register and the output
  // slot is empty or being emptied this cycle.
  assign adv        = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_rst_n_q   <= reset_button_n_i;
      s1_start_n_q <= start_button_n_i;
      s1_mclk_q    <= minute_enc_clk_i;
      s1_mdt_q     <= minute_enc_dt_i;
      s1_sclk_q    <= second_enc_clk_i;
      s1_sdt_q     <= second_enc_dt_i;
    end
  end

  // --------------------------------------------------------------------------
  // Timer state
  // --------------------------------------------------------------------------
  logic [rsct_pkg::MIN_W-1:0]  minutes_q, minutes_d;
  logic [rsct_pkg::SEC_W-1:0]  seconds_q, seconds_d;
  logic                        running_q, running_d;
  cnt_t                        sec_cnt_q, sec_cnt_d;
  cnt_t                        start_cnt_q, start_cnt_d;
  logic                        mclk_prev_q;
  cnt_t                        menc_cnt_q, menc_cnt_d;
  logic                        sclk_prev_q;
  cnt_t                        senc_cnt_q, senc_cnt_d;
  cnt_t                        blink_cnt_q, blink_cnt_d;
  logic                        warn_q, warn_d;
  logic [rsct_pkg::DISP_W-1:0] display_q, display_d;

  // One tick of the timer, in the order reset, start, countdown, stop at
  // zero, minute encoder, second encoder, warning pulse.
  always_comb begin
    logic  time_nz;
    cnt_t  cnt_inc;
    logic  m_chg, s_chg, m_step, s_step, m_down, s_down;
    cfg_t  period;

    minutes_d = minutes_q;
    seconds_d = seconds_q;
    running_d = running_q;
    warn_d    = 1'b0;
    period    = cfg_final_q;
    cnt_inc   = '0;

    if (!s1_rst_n_q) begin
      minutes_d = '0;
      seconds_d = '0;
      running_d = 1'b0;
    end

    // Start button toggles once per lockout interval while held.
    if (!s1_start_n_q && (cmp_t'(start_cnt_q) >= cmp_t'(cfg_start_q))) begin
      running_d   = ~running_d;
      start_cnt_d = '0;
    end else begin
      start_cnt_d = (&start_cnt_q) ? start_cnt_q : start_cnt_q + COUNT_WIDTH'(1);
    end

    // Countdown with borrow from minutes.
    time_nz = (minutes_d != '0) || (seconds_d != '0);
    if (running_d && time_nz) begin
      cnt_inc = (&sec_cnt_q) ? sec_cnt_q : sec_cnt_q + COUNT_WIDTH'(1);
      if (cmp_t'(cnt_inc) >= cmp_t'(cfg_tps_q)) begin
        sec_cnt_d = '0;
        if (seconds_d == '0) begin
          seconds_d = rsct_pkg::SEC_LAST;
          minutes_d = minutes_d - rsct_pkg::MIN_W'(1);
        end else begin
          seconds_d = seconds_d - rsct_pkg::SEC_W'(1);
        end
      end else begin
        sec_cnt_d = cnt_inc;
      end
    end else begin
      sec_cnt_d = '0;
    end

    if ((minutes_d == '0) && (seconds_d == '0)) begin
      running_d = 1'b0;
    end

    // Minute encoder: a clock change counts only after the lockout.
    m_chg  = s1_mclk_q != mclk_prev_q;
    m_step = m_chg && (cmp_t'(menc_cnt_q) > cmp_t'(cfg_enc_q));
    m_down = s1_mclk_q == s1_mdt_q;
    menc_cnt_d = m_chg ? '0 :
                 ((&menc_cnt_q) ? menc_cnt_q : menc_cnt_q + COUNT_WIDTH'(1));
    if (m_step) begin
      if (!m_down) begin
        if (minutes_d < MaxMin) begin
          minutes_d = minutes_d + rsct_pkg::MIN_W'(1);
        end
      end else if (minutes_d != '0) begin
        minutes_d = minutes_d - rsct_pkg::MIN_W'(1);
      end
    end

    // Second encoder: steps of five seconds with carry and borrow.
    s_chg  = s1_sclk_q != sclk_prev_q;
    s_step = s_chg && (cmp_t'(senc_cnt_q) > cmp_t'(cfg_enc_q));
    s_down = s1_sclk_q == s1_sdt_q;
    senc_cnt_d = s_chg ? '0 :
                 ((&senc_cnt_q) ? senc_cnt_q : senc_cnt_q + COUNT_WIDTH'(1));
    if (s_step) begin
      if (!s_down) begin
        if (seconds_d >= rsct_pkg::SEC_WRAP_FROM) begin
          if (minutes_d < MaxMin) begin
            seconds_d = '0;
            minutes_d = minutes_d + rsct_pkg::MIN_W'(1);
          end
        end else begin
          seconds_d = seconds_d + rsct_pkg::SEC_STEP;
        end
      end else if (seconds_d == '0) begin
        if (minutes_d != '0) begin
          minutes_d = minutes_d - rsct_pkg::MIN_W'(1);
          seconds_d = rsct_pkg::SEC_BORROW;
        end
      end else begin
        seconds_d = (seconds_d >= rsct_pkg::SEC_STEP) ?
                    seconds_d - rsct_pkg::SEC_STEP : '0;
      end
    end

    // Warning pulse, faster as the end approaches.
    if (running_d && (minutes_d < rsct_pkg::MIN_WARN)) begin
      if (minutes_d >= rsct_pkg::MIN_FAR) begin
        period = cfg_far_q;
      end else if (minutes_d == rsct_pkg::MIN_NEAR) begin
        period = cfg_near_q;
      end else if (seconds_d > rsct_pkg::SEC_FINAL) begin
        period = cfg_last_q;
      end else begin
        period = cfg_final_q;
      end
      blink_cnt_d = (&blink_cnt_q) ? blink_cnt_q : blink_cnt_q + COUNT_WIDTH'(1);
      if (cmp_t'(blink_cnt_d) >= cmp_t'(period)) begin
        blink_cnt_d = '0;
        warn_d      = 1'b1;
      end
    end else begin
      blink_cnt_d = '0;
    end

    display_d = rsct_pkg::DISP_W'(minutes_d) * rsct_pkg::DISP_SCALE
              + rsct_pkg::DISP_W'(seconds_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minutes_q   <= '0;
      seconds_q   <= '0;
      running_q   <= 1'b0;
      sec_cnt_q   <= '0;
      start_cnt_q <= '1;
      mclk_prev_q <= 1'b1;
      menc_cnt_q  <= '1;
      sclk_prev_q <= 1'b1;
      senc_cnt_q  <= '1;
      blink_cnt_q <= '0;
    end else if (adv) begin
      minutes_q   <= minutes_d;
      seconds_q   <= seconds_d;
      running_q   <= running_d;
      sec_cnt_q   <= sec_cnt_d;
      start_cnt_q <= start_cnt_d;
      mclk_prev_q <= s1_mclk_q;
      menc_cnt_q  <= menc_cnt_d;
      sclk_prev_q <= s1_sclk_q;
      senc_cnt_q  <= senc_cnt_d;
      blink_cnt_q <= blink_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      warn_q    <= warn_d;
      display_q <= display_d;
    end
  end

  // The timer state is updated only together with the output word, so it
  // doubles as the output register for the time and the running flag.
  assign out_valid_o     = out_valid_q;
  assign minutes_left_o  = minutes_q;
  assign seconds_left_o  = seconds_q;
  assign active_led_o    = running_q;
  assign warn_pulse_o    = warn_q;
  assign display_value_o = display_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic time_ok, warn_ok;

  assign time_ok = (minutes_q <= MaxMin) && (seconds_q <= rsct_pkg::SEC_LAST);
  assign warn_ok = running_q && (minutes_q < rsct_pkg::MIN_WARN);

  `RSCT_ASSERT_IMPLY(a_time_range, out_valid_q, time_ok, "time out of range")
  `RSCT_ASSERT_IMPLY(a_warn_window, out_valid_q && warn_q, warn_ok, "warning outside window")
  `RSCT_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready_i, out_valid_q, "output word dropped")
  `RSCT_ASSERT_NEXT(a_state_hold, !adv, $stable({minutes_q, seconds_q, running_q}), "state moved")

endmodule

// ===== sim/rotary_set_countdown_timer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotary set countdown timer testbench
// Drives tick words into the timer, predicts every output word in a
// scoreboard and compares them field by field under random idling.
// ----------------------------------------------------------------------------
module rotary_set_countdown_timer_tb;

  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned NREGS        = 7;
  localparam int unsigned CNT_MAX      = (1 << rsct_pkg::COUNT_WIDTH_DEF) - 1;
  localparam int unsigned IDLE_PCT     = 16;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT  = 100000;

  // One tick word: button levels and encoder pin levels, MSB first.
  typedef struct packed {
    logic rst_n;
    logic start_n;
    logic mclk;
    logic mdt;
    logic sclk;
    logic sdt;
  } tick_t;

  // One timer reading, laid out in the order of the output ports.
  typedef struct packed {
    logic [rsct_pkg::MIN_W-1:0]  minutes;
    logic [rsct_pkg::SEC_W-1:0]  seconds;
    logic                        active;
    logic                        warn;
    logic [rsct_pkg::DISP_W-1:0] disp;
  } timer_out_t;

  typedef enum {TURN_NONE, TURN_UP, TURN_DOWN} turn_e;

  // Clock, reset and block ports.
  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic                         reset_button_n_i;
  logic                         start_button_n_i;
  logic                         minute_enc_clk_i;
  logic                         minute_enc_dt_i;
  logic                         second_enc_clk_i;
  logic                         second_enc_dt_i;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [rsct_pkg::MIN_W-1:0]   minutes_left_o;
  logic [rsct_pkg::SEC_W-1:0]   seconds_left_o;
  logic                         active_led_o;
  logic                         warn_pulse_o;
  logic [rsct_pkg::DISP_W-1:0]  display_value_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [rsct_pkg::PADDR_W-1:0] paddr;
  logic [rsct_pkg::PDATA_W-1:0] pwdata;
  logic [rsct_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  // Scoreboard: a private copy of the timer state and registers. Every
  // accepted tick word advances the copy by one tick and queues the reading
  // that the block must return for it.
  class timer_scoreboard;
    int unsigned cfg [NREGS];
    int unsigned mins;
    int unsigned secs;
    bit          running;
    int unsigned sec_cnt;
    int unsigned start_cnt;
    int unsigned blink_cnt;
    bit          enc_prev [2];
    int unsigned enc_cnt [2];
    timer_out_t  due_readings [$];
    int unsigned fail_count;
    int unsigned words_seen;

    function new();
      cfg[rsct_pkg::REG_TICKS_PER_SECOND]  = rsct_pkg::RST_TICKS_PER_SECOND;
      cfg[rsct_pkg::REG_START_LOCKOUT]     = rsct_pkg::RST_START_LOCKOUT;
      cfg[rsct_pkg::REG_ENCODER_LOCKOUT]   = rsct_pkg::RST_ENCODER_LOCKOUT;
      cfg[rsct_pkg::REG_BLINK_FAR]         = rsct_pkg::RST_BLINK_FAR;
      cfg[rsct_pkg::REG_BLINK_NEAR]        = rsct_pkg::RST_BLINK_NEAR;
      cfg[rsct_pkg::REG_BLINK_LAST_MINUTE] = rsct_pkg::RST_BLINK_LAST_MINUTE;
      cfg[rsct_pkg::REG_BLINK_FINAL]       = rsct_pkg::RST_BLINK_FINAL;
      mins       = 0;
      secs       = 0;
      running    = 1'b0;
      sec_cnt    = 0;
      start_cnt  = CNT_MAX;
      blink_cnt  = 0;
      enc_prev   = '{1'b1, 1'b1};
      enc_cnt    = '{CNT_MAX, CNT_MAX};
      fail_count = 0;
      words_seen = 0;
    endfunction

    function void set_register(rsct_pkg::cfg_reg_e idx,
                               logic [rsct_pkg::CFG_W-1:0] value);
      cfg[idx] = value;
    endfunction

    function int unsigned outstanding();
      return due_readings.size();
    endfunction

    task report(string what);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    function int unsigned bump(int unsigned c);
      return (c < CNT_MAX) ? c + 1 : CNT_MAX;
    endfunction

    // A clock level change counts as a detent only when the encoder has
    // been quiet for longer than the lockout. Any change restarts the count.
    function turn_e decode_turn(int e, bit clk, bit dt);
      turn_e turn = TURN_NONE;
      if (clk != enc_prev[e]) begin
        if (enc_cnt[e] > cfg[rsct_pkg::REG_ENCODER_LOCKOUT]) begin
          turn = (clk == dt) ? TURN_DOWN : TURN_UP;
        end
        enc_cnt[e] = 0;
      end else begin
        enc_cnt[e] = bump(enc_cnt[e]);
      end
      enc_prev[e] = clk;
      return turn;
    endfunction

    // Advances the timer by one tick and returns what it shows afterwards.
    function timer_out_t advance_tick(tick_t t);
      timer_out_t  o;
      int unsigned period;
      bit          pulse;
      turn_e       turn;
      pulse = 1'b0;

      if (!t.rst_n) begin
        mins    = 0;
        secs    = 0;
        running = 1'b0;
      end

      // A held button toggles again once the lockout has run out.
      if (!t.start_n && start_cnt >= cfg[rsct_pkg::REG_START_LOCKOUT]) begin
        running   = !running;
        start_cnt = 0;
      end else begin
        start_cnt = bump(start_cnt);
      end

      if (running && (mins != 0 || secs != 0)) begin
        sec_cnt = bump(sec_cnt);
        if (sec_cnt >= cfg[rsct_pkg::REG_TICKS_PER_SECOND]) begin
          sec_cnt = 0;
          if (secs == 0) begin
            secs = rsct_pkg::SEC_LAST;
            mins--;
          end else begin
            secs--;
          end
        end
      end else begin
        sec_cnt = 0;
      end

      if (mins == 0 && secs == 0) begin
        running = 1'b0;
      end

      turn = decode_turn(0, t.mclk, t.mdt);
      if (turn == TURN_UP) begin
        if (mins < rsct_pkg::MAX_MINUTES_DEF) begin
          mins++;
        end
      end else if (turn == TURN_DOWN) begin
        if (mins > 0) begin
          mins--;
        end
      end

      // The seconds encoder moves in steps of five with carry and borrow;
      // a carry at the top minute is refused outright.
      turn = decode_turn(1, t.sclk, t.sdt);
      if (turn == TURN_UP) begin
        if (secs + rsct_pkg::SEC_STEP >= rsct_pkg::SEC_LAST + 1) begin
          if (mins < rsct_pkg::MAX_MINUTES_DEF) begin
            secs = 0;
            mins++;
          end
        end else begin
          secs += rsct_pkg::SEC_STEP;
        end
      end else if (turn == TURN_DOWN) begin
        if (secs == 0) begin
          if (mins > 0) begin
            mins--;
            secs = rsct_pkg::SEC_BORROW;
          end
        end else begin
          secs = (secs >= rsct_pkg::SEC_STEP) ? secs - rsct_pkg::SEC_STEP : 0;
        end
      end

      if (running && mins < rsct_pkg::MIN_WARN) begin
        if (mins >= rsct_pkg::MIN_FAR) begin
          period = cfg[rsct_pkg::REG_BLINK_FAR];
        end else if (mins == rsct_pkg::MIN_NEAR) begin
          period = cfg[rsct_pkg::REG_BLINK_NEAR];
        end else if (secs > rsct_pkg::SEC_FINAL) begin
          period = cfg[rsct_pkg::REG_BLINK_LAST_MINUTE];
        end else begin
          period = cfg[rsct_pkg::REG_BLINK_FINAL];
        end
        blink_cnt = bump(blink_cnt);
        if (blink_cnt >= period) begin
          blink_cnt = 0;
          pulse     = 1'b1;
        end
      end else begin
        blink_cnt = 0;
      end

      o.minutes = rsct_pkg::MIN_W'(mins);
      o.seconds = rsct_pkg::SEC_W'(secs);
      o.active  = running;
      o.warn    = pulse;
      o.disp    = rsct_pkg::DISP_W'(mins * 100 + secs);
      return o;
    endfunction

    function void note_tick(tick_t t);
      due_readings.push_back(advance_tick(t));
    endfunction

    task check_reading(timer_out_t got);
      timer_out_t want;
      words_seen++;
      if (due_readings.size() == 0) begin
        report($sformatf("output word %0d arrived with nothing due", words_seen));
        return;
      end
      want = due_readings.pop_front();
      if (got.minutes !== want.minutes) begin
        report($sformatf("word %0d minutes_left %0d, want %0d",
                         words_seen, got.minutes, want.minutes));
      end
      if (got.seconds !== want.seconds) begin
        report($sformatf("word %0d seconds_left %0d, want %0d",
                         words_seen, got.seconds, want.seconds));
      end
      if (got.active !== want.active) begin
        report($sformatf("word %0d active_led %b, want %b",
                         words_seen, got.active, want.active));
      end
      if (got.warn !== want.warn) begin
        report($sformatf("word %0d warn_pulse %b, want %b",
                         words_seen, got.warn, want.warn));
      end
      if (got.disp !== want.disp) begin
        report($sformatf("word %0d display_value %0d, want %0d",
                         words_seen, got.disp, want.disp));
      end
    endtask
  endclass

  timer_scoreboard sb;

  // When set, neither side idles; this gives a long back-to-back stretch.
  bit          calm = 1'b0;
  int unsigned cycle_count = 0;

  // Pin levels of the two encoders as the stimulus turns them, kept across
  // phases so that the pins never jump. Index 0 is minutes, 1 is seconds.
  bit          pin_clk [2] = '{1'b1, 1'b1};
  bit          pin_dt [2] = '{1'b1, 1'b1};
  int unsigned spin_left [2] = '{0, 0};
  int unsigned held [2] = '{0, 0};
  int unsigned hold_goal [2] = '{0, 0};
  bit          spin_up [2];
  bit          spin_noise [2];

  rotary_set_countdown_timer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .reset_button_n_i (reset_button_n_i),
    .start_button_n_i (start_button_n_i),
    .minute_enc_clk_i (minute_enc_clk_i),
    .minute_enc_dt_i  (minute_enc_dt_i),
    .second_enc_clk_i (second_enc_clk_i),
    .second_enc_dt_i  (second_enc_dt_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .minutes_left_o   (minutes_left_o),
    .seconds_left_o   (seconds_left_o),
    .active_led_o     (active_led_o),
    .warn_pulse_o     (warn_pulse_o),
    .display_value_o  (display_value_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Receiving side: every handshake is checked against the oldest reading
  // due, and ready is dropped at random to stall the block.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_reading({minutes_left_o, seconds_left_o, active_led_o,
                          warn_pulse_o, display_value_o});
      end
      out_ready_i <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Guards against a hang anywhere in the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One APB transfer: a setup cycle, then the access cycle that completes at
  // the first edge with pready high. Back-to-back transfers chain directly,
  // so psel is only released by the caller.
  task automatic apb_transfer(input bit wr, input rsct_pkg::cfg_reg_e idx,
                              input logic [rsct_pkg::PDATA_W-1:0] wdata,
                              output logic [rsct_pkg::PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= rsct_pkg::PADDR_W'(4 * idx);
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    rdata = prdata;
  endtask

  // Writes all seven registers, mirrors them into the scoreboard and reads
  // each one back. Only called while no word is in flight.
  task automatic load_setting(input logic [0:NREGS-1][rsct_pkg::CFG_W-1:0] vals);
    logic [rsct_pkg::PDATA_W-1:0] rd;
    int                           i;
    for (i = 0; i < NREGS; i++) begin
      apb_transfer(1'b1, rsct_pkg::cfg_reg_e'(i), rsct_pkg::PDATA_W'(vals[i]), rd);
      sb.set_register(rsct_pkg::cfg_reg_e'(i), vals[i]);
    end
    for (i = 0; i < NREGS; i++) begin
      apb_transfer(1'b0, rsct_pkg::cfg_reg_e'(i), '0, rd);
      if (rd !== rsct_pkg::PDATA_W'(vals[i])) begin
        sb.report($sformatf("register %0d reads %0d, want %0d", i, rd, vals[i]));
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offers one tick word and returns at the edge where it is taken. Each
  // cycle before it may be an idle one; when none is, valid simply stays high.
  task automatic send_tick(input tick_t t);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {reset_button_n_i, start_button_n_i, minute_enc_clk_i, minute_enc_dt_i,
     second_enc_clk_i, second_enc_dt_i} <= t;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    sb.note_tick(t);
  endtask

  // Stops sending and waits until every reading due has come back, then
  // lets the two-stage pipeline settle.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random ticks. Each encoder is mostly turned in clean spins, a detent
  // after each hold of hold ticks, with some holds cut short inside the
  // lockout and some spins replaced by pin noise. The start button is pressed in
  // bursts, and reset comes about once in rst_odds ticks.
  task automatic run_ticks(input int unsigned count, input int unsigned hold,
                           input int unsigned up_pct, input int unsigned max_spin,
                           input int unsigned rst_odds);
    tick_t       t;
    int unsigned start_left;
    int unsigned n;
    int          e;
    start_left = 0;
    for (n = 0; n < count; n++) begin
      t.rst_n = ($urandom_range(0, rst_odds) != 0);
      if (start_left == 0 && $urandom_range(0, 39) == 0) begin
        start_left = $urandom_range(1, 8);
      end
      t.start_n = (start_left == 0);
      if (start_left != 0) begin
        start_left--;
      end

      for (e = 0; e < 2; e++) begin
        if (spin_left[e] == 0) begin
          held[e]++;
          if ($urandom_range(0, 9) == 0) begin
            spin_left[e]  = $urandom_range(1, max_spin);
            spin_up[e]    = ($urandom_range(0, 99) < up_pct);
            spin_noise[e] = ($urandom_range(0, 7) == 0);
          end else if ($urandom_range(0, 15) == 0) begin
            // Bounce on the data pin alone never moves the encoder.
            pin_dt[e] = !pin_dt[e];
          end
        end else if (spin_noise[e]) begin
          pin_clk[e] = $urandom_range(0, 1);
          pin_dt[e]  = $urandom_range(0, 1);
          spin_left[e]--;
        end else if (held[e] >= hold_goal[e]) begin
          // Up means clk and dt differ right after the clock edge.
          pin_clk[e] = !pin_clk[e];
          pin_dt[e]  = spin_up[e] ? !pin_clk[e] : pin_clk[e];
          held[e]    = 0;
          spin_left[e]--;
          hold_goal[e] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, hold)
                                                     : hold + $urandom_range(0, 2);
        end else begin
          held[e]++;
        end
      end

      t.mclk = pin_clk[0];
      t.mdt  = pin_dt[0];
      t.sclk = pin_clk[1];
      t.sdt  = pin_dt[1];
      send_tick(t);
    end
  endtask

  initial begin
    sb = new();
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    reset_button_n_i <= 1'b1;
    start_button_n_i <= 1'b1;
    minute_enc_clk_i <= 1'b1;
    minute_enc_dt_i  <= 1'b1;
    second_enc_clk_i <= 1'b1;
    second_enc_dt_i  <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Both lockouts are zero, so a detent counts as long as
    // the previous tick held the clock level; two ticks make one second.
    // Word bits are reset, start, minute clk/dt, second clk/dt.
    load_setting({16'd2, 16'd0, 16'd0, 16'd3, 16'd2, 16'd1, 16'd1});
    send_tick(6'b11_11_11);  // all pins idle high
    send_tick(6'b11_00_11);  // minute down at 0:00 is refused
    send_tick(6'b11_00_00);  // second down at 0:00 is refused
    send_tick(6'b11_10_00);  // minute up to 1:00
    send_tick(6'b11_10_10);  // seconds up to 1:05
    send_tick(6'b11_10_10);  // hold
    send_tick(6'b11_10_00);  // seconds down to 1:00
    send_tick(6'b11_10_11);  // second detent right after a change is locked out
    send_tick(6'b11_10_11);  // hold
    send_tick(6'b11_10_00);  // down from zero seconds borrows a minute, 0:55
    send_tick(6'b11_10_00);  // hold
    send_tick(6'b11_10_10);  // up from 55 carries into minutes, 1:00
    send_tick(6'b10_10_10);  // start pressed, timer runs
    send_tick(6'b10_10_10);  // still held, no lockout, so it stops again
    send_tick(6'b10_10_10);  // and runs again
    send_tick(6'b11_10_10);  // released, countdown into the last minute
    send_tick(6'b11_10_10);  // warning pulse every tick
    send_tick(6'b11_01_10);  // minute up while running
    send_tick(6'b11_01_10);  // hold
    send_tick(6'b01_01_10);  // reset alone, back to 0:00 and stopped
    send_tick(6'b00_00_00);  // every pin low
    send_tick(6'b11_11_11);  // every pin high, minute down at 0:00 refused, second detent locked out
    wait_drain();

    // Short periods so the countdown and all warning buckets are reached.
    // Halfway through, the sender waits for the block to empty completely.
    load_setting({16'd3, 16'd20, 16'd2, 16'd7, 16'd5, 16'd3, 16'd2});
    run_ticks(150, 3, 60, 12, 250);
    wait_drain();
    run_ticks(150, 3, 60, 12, 250);
    wait_drain();

    // Every register at its top value: no detent can ever pass the lockout.
    load_setting({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF});
    run_ticks(100, 2, 50, 6, 60);
    wait_drain();

    // Lockouts at zero and every period at one: one second and one pulse per tick.
    load_setting({16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1});
    run_ticks(200, 1, 70, 20, 300);
    wait_drain();

    // A long stretch with no idling on either side.
    calm = 1'b1;
    load_setting({16'd5, 16'd50, 16'd4, 16'd13, 16'd9, 16'd6, 16'd3});
    run_ticks(250, 5, 55, 12, 250);
    wait_drain();
    calm = 1'b0;

    // Fast upward spins without reset to run the minutes into the ceiling,
    // where further minute detents and second carries are refused.
    load_setting({16'd2000, 16'd10, 16'd0, 16'd40, 16'd30, 16'd20, 16'd10});
    run_ticks(300, 1, 97, 80, 100000);
    wait_drain();

    if (sb.fail_count == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
